// ===== design/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg: shared definitions for the LRU block cache
// Request codes, configuration constants, parameter defaults and the
// command and status structures passed between the top level and the store.
// ----------------------------------------------------------------------------
package lbc_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_BITS_DEF    = 64;
	localparam int DATA_BITS_DEF   = 64;

	localparam int               REQ_BITS   = 2;
	localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd2;

	localparam int               CAP_BITS  = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	localparam int CNT_BITS = 32;

	typedef struct packed {
		logic do_lookup;
		logic do_insert;
		logic do_clear;
	} lbc_cmd_t;

	typedef struct packed {
		logic found;
		logic evicted;
	} lbc_res_t;

endpackage

// ===== design/lru_block_cache_unit.sv =====
// Throughput: one request per cycle unless out_ready stalls a held result;
// the store is updated as a request leaves the input register, so the next
// request already sees the new contents; results wait in the result register.
// Reset (arst_n low): cache empty, counters zero, capacity 16, both pipeline
// registers empty. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// lru_block_cache_unit: fully associative LRU key/value cache
// Input register, match and update in the store, result register
// with saturating hit and miss counters and the capacity register.
// ----------------------------------------------------------------------------
module lru_block_cache_unit #(
	parameter int MAX_ENTRIES = lbc_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BITS    = lbc_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS   = lbc_pkg::DATA_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lbc_pkg::REQ_BITS-1:0]       req_type,
	input  logic [KEY_BITS-1:0]                key,
	input  logic [DATA_BITS-1:0]               write_data,

	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic [DATA_BITS-1:0]               read_data,
	output logic                               evicted,
	output logic [$clog2(MAX_ENTRIES+1)-1:0]   entries_used,
	output logic [lbc_pkg::CNT_BITS-1:0]       hit_count,
	output logic [lbc_pkg::CNT_BITS-1:0]       miss_count,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lbc_pkg::CAP_BITS-1:0]       cfg_data
);
	import lbc_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic                 valid_s1;
	logic [REQ_BITS-1:0]  req_s1;
	logic [KEY_BITS-1:0]  key_s1;
	logic [DATA_BITS-1:0] wdata_s1;

	logic                 valid_s2;
	logic                 found_s2;
	logic [DATA_BITS-1:0] rdata_s2;
	logic                 evicted_s2;
	logic [CW-1:0]        used_s2;
	logic [CNT_BITS-1:0]  hits_s2;
	logic [CNT_BITS-1:0]  misses_s2;

	logic [CAP_BITS-1:0]  capacity_q;
	logic [CNT_BITS-1:0]  hits_q;
	logic [CNT_BITS-1:0]  misses_q;

	logic                 advance;
	logic [CW-1:0]        limit;
	lbc_cmd_t             cmd;
	lbc_res_t             res;
	logic [DATA_BITS-1:0] hit_data;
	logic [CW-1:0]        count_next;
	logic [CNT_BITS-1:0]  hits_next;
	logic [CNT_BITS-1:0]  misses_next;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// A zero capacity behaves as one; anything above the array size saturates.
	always_comb begin
		if (capacity_q == '0) begin
			limit = CW'(1);
		end else if (32'(capacity_q) > MAX_ENTRIES) begin
			limit = CW'(MAX_ENTRIES);
		end else begin
			limit = CW'(capacity_q);
		end
	end

	always_comb begin
		cmd = '0;
		if (advance) begin
			case (req_s1)
				REQ_LOOKUP: cmd.do_lookup = 1'b1;
				REQ_INSERT: cmd.do_insert = 1'b1;
				REQ_CLEAR:  cmd.do_clear  = 1'b1;
				default:    cmd = '0;
			endcase
		end
	end

	lbc_store #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_BITS    (KEY_BITS),
		.DATA_BITS   (DATA_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.key        (key_s1),
		.wdata      (wdata_s1),
		.limit      (limit),
		.res        (res),
		.hit_data   (hit_data),
		.count_next (count_next)
	);

	always_comb begin
		hits_next   = hits_q;
		misses_next = misses_q;
		if (cmd.do_clear) begin
			hits_next   = '0;
			misses_next = '0;
		end else if (cmd.do_lookup) begin
			if (res.found) begin
				if (hits_q != '1) begin
					hits_next = hits_q + CNT_BITS'(1);
				end
			end else if (misses_q != '1) begin
				misses_next = misses_q + CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			capacity_q <= CAP_RESET;
			hits_q     <= '0;
			misses_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_valid) begin
				capacity_q <= cfg_data;
			end
			if (advance) begin
				hits_q   <= hits_next;
				misses_q <= misses_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1   <= req_type;
			key_s1   <= key;
			wdata_s1 <= write_data;
		end
		if (advance) begin
			found_s2   <= res.found;
			rdata_s2   <= (cmd.do_lookup && res.found) ? hit_data : '0;
			evicted_s2 <= res.evicted;
			used_s2    <= count_next;
			hits_s2    <= hits_next;
			misses_s2  <= misses_next;
		end
	end

	assign out_valid    = valid_s2;
	assign found        = found_s2;
	assign read_data    = rdata_s2;
	assign evicted      = evicted_s2;
	assign entries_used = used_s2;
	assign hit_count    = hits_s2;
	assign miss_count   = misses_s2;

endmodule

// ===== design/lbc_store.sv =====
// ----------------------------------------------------------------------------
// lbc_store: entry array with parallel tag match and recency update
// Holds the valid bits, keys, data words and recency ranks of all entries,
// matches the request key against every entry at once and applies the lookup,
// insert (with least-recent eviction) or clear update.
// ----------------------------------------------------------------------------
module lbc_store #(
	parameter int MAX_ENTRIES = lbc_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BITS    = lbc_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS   = lbc_pkg::DATA_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lbc_pkg::lbc_cmd_t                  cmd,
	input  logic [KEY_BITS-1:0]                key,
	input  logic [DATA_BITS-1:0]               wdata,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0]   limit,
	output lbc_pkg::lbc_res_t                  res,
	output logic [DATA_BITS-1:0]               hit_data,
	output logic [$clog2(MAX_ENTRIES+1)-1:0]   count_next
);
	import lbc_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [MAX_ENTRIES-1:0] valid_q;
	logic [RW-1:0]          rank_q [MAX_ENTRIES];
	logic [KEY_BITS-1:0]    key_q  [MAX_ENTRIES];
	logic [DATA_BITS-1:0]   data_q [MAX_ENTRIES];
	logic [CW-1:0]          count_q;

	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] victim;
	logic [MAX_ENTRIES-1:0] valid_ev;
	logic [MAX_ENTRIES-1:0] free_slot;
	logic [MAX_ENTRIES-1:0] valid_d;
	logic [MAX_ENTRIES-1:0] wr_key;
	logic [MAX_ENTRIES-1:0] wr_data;
	logic [RW-1:0]          rank_d [MAX_ENTRIES];
	logic [RW-1:0]          hit_rank;
	logic [RW-1:0]          oldest_rank;
	logic [CW-1:0]          count_m1;
	logic                   hit;
	logic                   need_evict;
	logic                   free_seen;

	// Ranks of valid entries are always 0 .. count-1 without gaps, so the
	// least recent entry is the one whose rank equals count minus one.
	assign count_m1    = count_q - CW'(1);
	assign oldest_rank = count_m1[RW-1:0];

	always_comb begin
		hit_data = '0;
		hit_rank = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i]  = valid_q[i] && (key_q[i] == key);
			victim[i] = valid_q[i] && (rank_q[i] == oldest_rank);
			if (match[i]) begin
				hit_data = hit_data | data_q[i];
				hit_rank = hit_rank | rank_q[i];
			end
		end
		hit        = |match;
		need_evict = !hit && (count_q >= limit) && (count_q != '0);
		valid_ev   = need_evict ? (valid_q & ~victim) : valid_q;

		free_seen = 1'b0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			free_slot[i] = !valid_ev[i] && !free_seen;
			if (!valid_ev[i]) begin
				free_seen = 1'b1;
			end
		end
	end

	always_comb begin
		valid_d    = valid_q;
		wr_key     = '0;
		wr_data    = '0;
		count_next = count_q;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
		end

		if (cmd.do_clear) begin
			valid_d    = '0;
			count_next = '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_d[i] = '0;
			end
		end else if ((cmd.do_lookup || cmd.do_insert) && hit) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (match[i]) begin
					rank_d[i] = '0;
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_d[i] = rank_q[i] + RW'(1);
				end
			end
			if (cmd.do_insert) begin
				wr_data = match;
			end
		end else if (cmd.do_insert) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (free_slot[i]) begin
					valid_d[i] = 1'b1;
					rank_d[i]  = '0;
				end else if (valid_ev[i]) begin
					rank_d[i] = rank_q[i] + RW'(1);
				end else begin
					valid_d[i] = 1'b0;
					rank_d[i]  = '0;
				end
			end
			wr_key     = free_slot;
			wr_data    = free_slot;
			count_next = need_evict ? count_q : count_q + CW'(1);
		end
	end

	assign res.found   = hit && (cmd.do_lookup || cmd.do_insert);
	assign res.evicted = cmd.do_insert && need_evict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			count_q <= count_next;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (wr_key[i]) begin
				key_q[i] <= key;
			end
			if (wr_data[i]) begin
				data_q[i] <= wdata;
			end
		end
	end

endmodule
